// ===== rtl/gaussian_log_likelihood_accumulator_core_assert.svh =====
// assertion macros used by the rtl of the log-likelihood accumulator
`ifndef GAUSSIAN_LOG_LIKELIHOOD_ACCUMULATOR_CORE_ASSERT_SVH
`define GAUSSIAN_LOG_LIKELIHOOD_ACCUMULATOR_CORE_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define GLLA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("glla assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define GLLA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("glla assertion failed");

`endif

// ===== rtl/glla_pkg.sv =====
// types and constants of the log-likelihood accumulator
`default_nettype none

package glla_pkg;

	localparam int ACC_W         = 48;
	localparam int LOG_FRAC_BITS = 30;
	localparam int SQ_STEPS      = 30;
	localparam int DIV_STEPS     = 65;
	localparam int CNT_W         = 7;

	localparam logic [29:0]        LN2_Q30    = 30'd744261118;
	localparam logic [32:0]        TWO_PI_Q30 = 33'd6746518852;
	localparam logic signed [7:0]  TWO_PI_EXP = 8'sd2;
	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	typedef enum logic [3:0] {
		S_IDLE, S_DECIDE, S_SV, S_MULAD, S_DIVI, S_DIV, S_LOGSV, S_NORM,
		S_SQM, S_SQU, S_FRM, S_LNACC, S_LOGPI, S_CACC, S_FACC, S_FINISH
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_MUL_SV, OP_SV, OP_MUL_AD, OP_DIV_INIT, OP_DIV_STEP,
		OP_LOG_SV, OP_LOG_W, OP_LOG_PI, OP_NORM, OP_SQ_MUL, OP_SQ_UPD,
		OP_FRAC_MUL, OP_LOG_ACC, OP_CLUSTER_ACC, OP_FIELD_ACC, OP_FIELD_MAX,
		OP_DEAD, OP_OUT
	} op_t;

	typedef enum logic [1:0] {PH_FIELD, PH_SV, PH_PI} phase_t;

	typedef struct packed {
		logic dead;
		logic is_field;
		logic in_range;
		logic width_zero;
		logic var_zero;
		logic last;
		logic norm_done;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/glla_datapath.sv =====
// datapath: operand registers, shared multiplier, divider, log unit, accumulator
`default_nettype none

module glla_datapath #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_wr_en,
	input  wire logic [31:0]         cfg_wr_data,
	input  wire glla_pkg::op_t       op,
	input  wire logic signed [31:0]  observed_mag,
	input  wire logic signed [31:0]  model_mag,
	input  wire logic [31:0]         mag_variance,
	input  wire logic signed [31:0]  field_low,
	input  wire logic signed [31:0]  field_high,
	input  wire logic                is_field,
	input  wire logic                last_filter,
	output glla_pkg::dp_status_t     status,
	output logic signed [47:0]       log_like,
	output logic                     minus_infinity
);
	import glla_pkg::*;

	localparam int SV_W   = 64 - FRAC_BITS;
	localparam int SHIFT  = LOG_FRAC_BITS - FRAC_BITS;
	localparam int LN_W   = 40;
	localparam int TERM_W = ACC_W + 1;
	localparam int SUM_W  = ACC_W + 2;
	localparam int MUL_W  = 33;
	localparam logic signed [LN_W-1:0] LN_RND = LN_W'(64'd1 << (SHIFT - 1));

	function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
		if (v > SUM_W'(ACC_MAX))
			return ACC_MAX;
		else if (v < SUM_W'(ACC_MIN))
			return ACC_MIN;
		else
			return v[ACC_W-1:0];
	endfunction

	logic [31:0]             scale_q;
	logic signed [31:0]      obs_q, mdl_q, lo_q, hi_q;
	logic [31:0]             var_q;
	logic                    field_q, last_q;
	logic [2*MUL_W-1:0]      mul_q;
	logic [MUL_W-1:0]        mul_a, mul_b;
	logic [SV_W-1:0]         sv_q;
	logic [SV_W-1:0]         rem_q;
	logic [DIV_STEPS-1:0]    quo_q;
	logic [63:0]             x_q;
	logic signed [7:0]       exp_q;
	logic [SQ_STEPS-1:0]     frac_q;
	logic signed [LN_W-1:0]  lnsum_q;
	logic signed [ACC_W-1:0] acc_q;
	logic                    dead_q;

	logic signed [32:0]      diff, width;
	logic [32:0]             ad;
	logic [63:0]             prod_sh;
	logic [SV_W-1:0]         sv_new;
	logic [SV_W:0]           div_t;
	logic                    div_ge;
	logic [SV_W-1:0]         rem_d;
	logic [ACC_W-2:0]        q_sat;
	logic [32:0]             sq;
	logic signed [LN_W-1:0]  ln_exp, ln_frac, lnf;
	logic signed [TERM_W-1:0] term, half;

	// operand arithmetic
	always_comb begin
		diff    = 33'(mdl_q) - 33'(obs_q);
		ad      = diff[32] ? 33'(-diff) : 33'(diff);
		width   = 33'(hi_q) - 33'(lo_q);
		prod_sh = mul_q[63:0] >> FRAC_BITS;
		sv_new  = (prod_sh[SV_W-1:0] == '0) ? SV_W'(1) : prod_sh[SV_W-1:0];
		div_t   = {rem_q, quo_q[DIV_STEPS-1]};
		div_ge  = div_t >= {1'b0, sv_q};
		rem_d   = div_ge ? SV_W'(div_t - {1'b0, sv_q}) : div_t[SV_W-1:0];
		q_sat   = (|quo_q[DIV_STEPS-1:ACC_W-1]) ? {(ACC_W-1){1'b1}} : quo_q[ACC_W-2:0];
		sq      = mul_q[63:31];
		ln_exp  = LN_W'(exp_q) * $signed(LN_W'(LN2_Q30));
		ln_frac = $signed(LN_W'(mul_q[59:30]));
		lnf     = (lnsum_q + LN_RND) >>> SHIFT;
		term    = TERM_W'(lnf) + $signed({2'b00, q_sat});
		half    = term >>> 1;
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (op)
			OP_MUL_SV: begin
				mul_a = {1'b0, scale_q};
				mul_b = {1'b0, var_q};
			end
			OP_MUL_AD: begin
				mul_a = ad;
				mul_b = ad;
			end
			OP_SQ_MUL: begin
				mul_a = {1'b0, x_q[63:32]};
				mul_b = {1'b0, x_q[63:32]};
			end
			OP_FRAC_MUL: begin
				mul_a = MUL_W'(frac_q);
				mul_b = MUL_W'(LN2_Q30);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= 32'(64'd1 << FRAC_BITS);
		end else if (cfg_wr_en) begin
			scale_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			dead_q <= 1'b0;
		end else begin
			case (op)
				OP_FIELD_MAX:   acc_q <= ACC_MAX;
				OP_FIELD_ACC:   acc_q <= sat_acc(SUM_W'(acc_q) - SUM_W'(lnf));
				OP_CLUSTER_ACC: acc_q <= sat_acc(SUM_W'(acc_q) - SUM_W'(half));
				OP_DEAD:        dead_q <= 1'b1;
				OP_OUT: begin
					acc_q  <= '0;
					dead_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				obs_q   <= observed_mag;
				mdl_q   <= model_mag;
				var_q   <= mag_variance;
				lo_q    <= field_low;
				hi_q    <= field_high;
				field_q <= is_field;
				last_q  <= last_filter;
				lnsum_q <= '0;
			end
			OP_MUL_SV, OP_MUL_AD, OP_SQ_MUL, OP_FRAC_MUL: mul_q <= mul_a * mul_b;
			OP_SV: sv_q <= sv_new;
			OP_DIV_INIT: begin
				rem_q <= '0;
				quo_q <= mul_q[DIV_STEPS-1:0];
			end
			OP_DIV_STEP: begin
				rem_q <= rem_d;
				quo_q <= {quo_q[DIV_STEPS-2:0], div_ge};
			end
			OP_LOG_SV: begin
				x_q    <= 64'(sv_q);
				exp_q  <= 8'(63 - FRAC_BITS);
				frac_q <= '0;
			end
			OP_LOG_W: begin
				x_q    <= 64'(width[31:0]);
				exp_q  <= 8'(63 - FRAC_BITS);
				frac_q <= '0;
			end
			OP_LOG_PI: begin
				x_q    <= {TWO_PI_Q30, 31'd0};
				exp_q  <= TWO_PI_EXP;
				frac_q <= '0;
			end
			OP_NORM: begin
				x_q   <= {x_q[62:0], 1'b0};
				exp_q <= exp_q - 8'sd1;
			end
			OP_SQ_UPD: begin
				x_q[63:32] <= sq[32] ? sq[32:1] : sq[31:0];
				frac_q     <= {frac_q[SQ_STEPS-2:0], sq[32]};
			end
			OP_LOG_ACC: lnsum_q <= lnsum_q + ln_exp + ln_frac;
			OP_OUT: begin
				log_like       <= dead_q ? ACC_MIN : acc_q;
				minus_infinity <= dead_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		status.dead       = dead_q;
		status.is_field   = field_q;
		status.in_range   = (lo_q <= obs_q) && (obs_q <= hi_q);
		status.width_zero = (lo_q == hi_q);
		status.var_zero   = (var_q == 32'd0);
		status.last       = last_q;
		status.norm_done  = x_q[63];
	end

endmodule

`default_nettype wire

// ===== rtl/glla_controller.sv =====
// controller: sequences the datapath through one filter transaction
`default_nettype none

module glla_controller (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic                 out_stall,
	input  wire glla_pkg::dp_status_t status,
	output glla_pkg::op_t             op,
	output logic                      in_stall,
	output logic                      out_valid
);
	import glla_pkg::*;

	state_t             state_q, state_d;
	phase_t             phase_q, phase_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic               out_valid_q;
	logic               out_free;

	assign out_free = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		cnt_d   = cnt_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_DECIDE;
			S_DECIDE: begin
				if (status.dead) begin
					state_d = S_FINISH;
				end else if (status.is_field) begin
					if (status.in_range && !status.width_zero) begin
						state_d = S_NORM;
						phase_d = PH_FIELD;
					end else begin
						state_d = S_FINISH;
					end
				end else if (status.var_zero) begin
					state_d = S_FINISH;
				end else begin
					state_d = S_SV;
				end
			end
			S_SV:    state_d = S_MULAD;
			S_MULAD: state_d = S_DIVI;
			S_DIVI: begin
				state_d = S_DIV;
				cnt_d   = '0;
			end
			S_DIV: begin
				if (cnt_q == CNT_W'(DIV_STEPS - 1))
					state_d = S_LOGSV;
				else
					cnt_d = cnt_q + 1'b1;
			end
			S_LOGSV: begin
				state_d = S_NORM;
				phase_d = PH_SV;
			end
			S_NORM: begin
				if (status.norm_done) begin
					state_d = S_SQM;
					cnt_d   = '0;
				end
			end
			S_SQM: state_d = S_SQU;
			S_SQU: begin
				if (cnt_q == CNT_W'(SQ_STEPS - 1)) begin
					state_d = S_FRM;
				end else begin
					state_d = S_SQM;
					cnt_d   = cnt_q + 1'b1;
				end
			end
			S_FRM: state_d = S_LNACC;
			S_LNACC: begin
				unique case (phase_q)
					PH_FIELD: state_d = S_FACC;
					PH_SV:    state_d = S_LOGPI;
					default:  state_d = S_CACC;
				endcase
			end
			S_LOGPI: begin
				state_d = S_NORM;
				phase_d = PH_PI;
			end
			S_CACC: state_d = S_FINISH;
			S_FACC: state_d = S_FINISH;
			S_FINISH: begin
				if (!status.last || out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		op = OP_NONE;
		unique case (state_q)
			S_IDLE: if (in_valid) op = OP_LOAD;
			S_DECIDE: begin
				if (status.dead)
					op = OP_NONE;
				else if (status.is_field)
					op = !status.in_range ? OP_DEAD :
						(status.width_zero ? OP_FIELD_MAX : OP_LOG_W);
				else if (!status.var_zero)
					op = OP_MUL_SV;
			end
			S_SV:     op = OP_SV;
			S_MULAD:  op = OP_MUL_AD;
			S_DIVI:   op = OP_DIV_INIT;
			S_DIV:    op = OP_DIV_STEP;
			S_LOGSV:  op = OP_LOG_SV;
			S_NORM:   if (!status.norm_done) op = OP_NORM;
			S_SQM:    op = OP_SQ_MUL;
			S_SQU:    op = OP_SQ_UPD;
			S_FRM:    op = OP_FRAC_MUL;
			S_LNACC:  op = OP_LOG_ACC;
			S_LOGPI:  op = OP_LOG_PI;
			S_CACC:   op = OP_CLUSTER_ACC;
			S_FACC:   op = OP_FIELD_ACC;
			S_FINISH: if (status.last && out_free) op = OP_OUT;
			default:  op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_FIELD;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			if (op == OP_OUT)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/gaussian_log_likelihood_accumulator_core.sv =====
// top level of the gaussian log-likelihood accumulator
// one input transaction is one filter measurement of a star; the block
// subtracts that filter's gaussian term (cluster star) or uniform term
// (field star) from a saturating 48-bit accumulator in signed fixed point
// with FRAC_BITS fraction bits, and on the transaction flagged last_filter it
// hands out one result transaction and clears the accumulator. one item is
// worked at a time; in_stall stays high until it is done. each item is
// worked by a shared 33x33 multiplier, a one-bit-per-cycle restoring
// divider for diff^2/(scale*var) and a squaring log2 unit (a left shift per
// leading zero for normalisation, then 30 square-and-test steps): a cluster
// item's run grows with the leading zeros of the scaled variance, a field
// item's inside its bounds with those of the width; a skipped, dead or
// out-of-bounds item skips the arithmetic. a finished result sits in an output
// register, so a new item is taken while that result is still stalled; a last
// item waits only if the previous result has not yet gone. variance_scale is
// written through cfg_wr_en / cfg_wr_data; the user must do so only while the
// block is idle, as the block itself does not enforce it
`default_nettype none

module gaussian_log_likelihood_accumulator_core #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [31:0]        cfg_wr_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [31:0] observed_mag,
	input  wire logic signed [31:0] model_mag,
	input  wire logic [31:0]        mag_variance,
	input  wire logic signed [31:0] field_low,
	input  wire logic signed [31:0] field_high,
	input  wire logic               is_field,
	input  wire logic               last_filter,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [47:0]      log_like,
	output logic                    minus_infinity
);
	import glla_pkg::*;

	// command from the controller, status back from the datapath
	op_t        op;
	dp_status_t status;

	glla_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.status    (status),
		.op        (op),
		.in_stall  (in_stall),
		.out_valid (out_valid)
	);

	glla_datapath #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.op             (op),
		.observed_mag   (observed_mag),
		.model_mag      (model_mag),
		.mag_variance   (mag_variance),
		.field_low      (field_low),
		.field_high     (field_high),
		.is_field       (is_field),
		.last_filter    (last_filter),
		.status         (status),
		.log_like       (log_like),
		.minus_infinity (minus_infinity)
	);

	`include "gaussian_log_likelihood_accumulator_core_assert.svh"

	// an accepted transaction always makes the block busy on the next cycle
	`GLLA_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	// publishing a result always raises out_valid
	`GLLA_ASSERT_NXT(a_valid_after_publish, op == OP_OUT, out_valid)
	// a dead star reports the most negative log-likelihood
	`GLLA_ASSERT_IMP(a_dead_value, out_valid && minus_infinity, log_like == ACC_MIN)

endmodule

`default_nettype wire
